// ----- sv/json_bracket_balance_checker_top_assert.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the JSON bracket balance checker
// Shared concurrent-assertion wrappers on clk, disabled during rst_n low.
// ---------------------------------------------------------------------------
`ifndef JSON_BRACKET_BALANCE_CHECKER_TOP_ASSERT_SVH
`define JSON_BRACKET_BALANCE_CHECKER_TOP_ASSERT_SVH

// same-cycle implication
`define JBBC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define JBBC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/jbbc_pkg.sv -----
// ---------------------------------------------------------------------------
// jbbc_pkg
// Types, constants and helpers shared by the bracket balance checker.
// ---------------------------------------------------------------------------
package jbbc_pkg;

    localparam int DEPTH_BITS = 16;
    localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = '1;

    localparam logic [7:0] CH_LBRACE   = 8'h7B;
    localparam logic [7:0] CH_RBRACE   = 8'h7D;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_RBRACKET = 8'h5D;
    localparam logic [7:0] CH_BSLASH   = 8'h5C;
    localparam logic [7:0] CH_QUOTE    = 8'h22;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_TAB      = 8'h09;
    localparam logic [7:0] CH_CR       = 8'h0D;

    typedef enum logic [2:0] {
        ERR_NONE          = 3'd0,
        ERR_STRAY_BRACE   = 3'd1,
        ERR_STRAY_BRACKET = 3'd2,
        ERR_UNCLOSED      = 3'd3,
        ERR_BAD_FIRST     = 3'd4,
        ERR_BAD_LAST      = 3'd5,
        ERR_OVERFLOW      = 3'd6
    } reason_t;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       final_byte;
    } beat_t;

    typedef struct packed {
        logic    is_valid;
        reason_t fail_reason;
    } verdict_t;

    function automatic logic is_space(input logic [7:0] b);
        return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
    endfunction

    function automatic logic is_opener(input logic [7:0] b);
        return (b == CH_LBRACE) || (b == CH_LBRACKET);
    endfunction

    function automatic logic is_closer(input logic [7:0] b);
        return (b == CH_RBRACE) || (b == CH_RBRACKET);
    endfunction

    // first error sticks
    function automatic reason_t note_err(input reason_t held, input reason_t code);
        return (held == ERR_NONE) ? code : held;
    endfunction

endpackage

// ----- sv/jbbc_in_stage.sv -----
// ---------------------------------------------------------------------------
// jbbc_in_stage
// Input register; holds one beat until the scan stage takes it.
// ---------------------------------------------------------------------------
module jbbc_in_stage
    import jbbc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_stall,
    input  beat_t in_beat,
    input  logic  advance,
    output logic  held_valid,
    output beat_t held_beat
);

    logic  valid_reg;
    logic  valid_next;
    beat_t beat_reg;
    logic  accept;

    assign in_stall   = valid_reg & ~advance;
    assign accept     = in_valid & ~in_stall;
    assign valid_next = accept | (valid_reg & ~advance);
    assign held_valid = valid_reg;
    assign held_beat  = beat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            beat_reg <= in_beat;
        end
    end

endmodule

// ----- sv/jbbc_scan.sv -----
// ---------------------------------------------------------------------------
// jbbc_scan
// Depth counters, string/escape flags, sticky error and end-of-text verdict.
// ---------------------------------------------------------------------------
module jbbc_scan
    import jbbc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     step,
    input  beat_t    beat,
    output verdict_t verdict
);

`include "json_bracket_balance_checker_top_assert.svh"

    logic [DEPTH_BITS-1:0] brace_reg,   brace_next;
    logic [DEPTH_BITS-1:0] bracket_reg, bracket_next;
    logic    quote_reg,    quote_next;
    logic    skip_reg,     skip_next;
    logic    awaiting_reg, awaiting_next;
    logic    first_reg,    first_next;
    logic    last_reg,     last_next;
    reason_t err_reg,      err_next;
    reason_t reason;
    logic [7:0] b;

    assign b = beat.text_byte;

    always_comb
    begin
        brace_next    = brace_reg;
        bracket_next  = bracket_reg;
        quote_next    = quote_reg;
        skip_next     = skip_reg;
        awaiting_next = awaiting_reg;
        first_next    = first_reg;
        last_next     = last_reg;
        err_next      = err_reg;
        reason        = ERR_NONE;

        if (step)
        begin
            if (awaiting_reg)
            begin
                first_next    = is_opener(b);
                awaiting_next = 1'b0;
            end
            if (!is_space(b))
            begin
                last_next = is_closer(b);
            end

            if (skip_reg)
            begin
                skip_next = 1'b0;
            end
            else if (b == CH_BSLASH)
            begin
                skip_next = 1'b1;
            end
            else if (b == CH_QUOTE)
            begin
                quote_next = ~quote_reg;
            end
            else if (!quote_reg)
            begin
                case (b)
                    CH_LBRACE:
                    begin
                        if (brace_reg == DEPTH_MAX)
                            err_next = note_err(err_reg, ERR_OVERFLOW);
                        else
                            brace_next = brace_reg + 1'b1;
                    end
                    CH_RBRACE:
                    begin
                        if (brace_reg == '0)
                            err_next = note_err(err_reg, ERR_STRAY_BRACE);
                        else
                            brace_next = brace_reg - 1'b1;
                    end
                    CH_LBRACKET:
                    begin
                        if (bracket_reg == DEPTH_MAX)
                            err_next = note_err(err_reg, ERR_OVERFLOW);
                        else
                            bracket_next = bracket_reg + 1'b1;
                    end
                    CH_RBRACKET:
                    begin
                        if (bracket_reg == '0)
                            err_next = note_err(err_reg, ERR_STRAY_BRACKET);
                        else
                            bracket_next = bracket_reg - 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
            end

            if (beat.final_byte)
            begin
                if (err_next != ERR_NONE)
                    reason = err_next;
                else if ((brace_next != '0) || (bracket_next != '0))
                    reason = ERR_UNCLOSED;
                else if (!first_next)
                    reason = ERR_BAD_FIRST;
                else if (!last_next)
                    reason = ERR_BAD_LAST;
                else
                    reason = ERR_NONE;

                // back to the idle state for the next text
                brace_next    = '0;
                bracket_next  = '0;
                quote_next    = 1'b0;
                skip_next     = 1'b0;
                awaiting_next = 1'b1;
                first_next    = 1'b0;
                last_next     = 1'b0;
                err_next      = ERR_NONE;
            end
        end
    end

    assign verdict.is_valid    = (reason == ERR_NONE);
    assign verdict.fail_reason = reason;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            brace_reg    <= '0;
            bracket_reg  <= '0;
            quote_reg    <= 1'b0;
            skip_reg     <= 1'b0;
            awaiting_reg <= 1'b1;
            first_reg    <= 1'b0;
            last_reg     <= 1'b0;
            err_reg      <= ERR_NONE;
        end
        else
        begin
            brace_reg    <= brace_next;
            bracket_reg  <= bracket_next;
            quote_reg    <= quote_next;
            skip_reg     <= skip_next;
            awaiting_reg <= awaiting_next;
            first_reg    <= first_next;
            last_reg     <= last_next;
            err_reg      <= err_next;
        end
    end

    `JBBC_ASSERT_NEXT(a_final_clears,
        step && beat.final_byte,
        awaiting_reg && (brace_reg == '0) && (bracket_reg == '0) && !quote_reg
            && !skip_reg && (err_reg == ERR_NONE),
        "scan state not cleared after final beat")

    `JBBC_ASSERT_NEXT(a_error_sticky,
        (err_reg != ERR_NONE) && !(step && beat.final_byte),
        err_reg == $past(err_reg),
        "held error changed before end of text")

    `JBBC_ASSERT_NEXT(a_brace_count,
        step && !beat.final_byte && !skip_reg && !quote_reg && (b == CH_LBRACE)
            && (brace_reg != DEPTH_MAX),
        brace_reg == $past(brace_reg) + 1'b1,
        "brace depth did not count up")

endmodule

// ----- sv/jbbc_out_stage.sv -----
// ---------------------------------------------------------------------------
// jbbc_out_stage
// Result register; holds a verdict until the receiver takes the beat.
// ---------------------------------------------------------------------------
module jbbc_out_stage
    import jbbc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     load,
    input  verdict_t verdict,
    output logic     out_valid,
    input  logic     out_stall,
    output logic     is_valid,
    output logic [2:0] fail_reason
);

    logic     valid_reg;
    logic     valid_next;
    verdict_t verdict_reg;

    assign valid_next  = load | (valid_reg & out_stall);
    assign out_valid   = valid_reg;
    assign is_valid    = verdict_reg.is_valid;
    assign fail_reason = verdict_reg.fail_reason;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            verdict_reg <= verdict;
        end
    end

endmodule

// ----- sv/json_bracket_balance_checker_top.sv -----
// ---------------------------------------------------------------------------
// json_bracket_balance_checker_top
// Streams a text one byte per beat and gives a pass/fail verdict with a
// reason code for the text once the beat that carries its final byte is scanned.
// ---------------------------------------------------------------------------
//
//  channel | handshake               | payload
//  --------+-------------------------+---------------------------------
//  in      | in_valid / in_stall     | text_byte[7:0], final_byte
//  out     | out_valid / out_stall   | is_valid, fail_reason[2:0]
//
//  Throughput: one byte per cycle while no final byte waits on out_stall;
//  the scan stage updates its depth counters and flags as each byte is taken.
//  Path: a final byte's verdict goes through the input register, then the
//  result register, before it shows on out_valid.
//  Reset: rst_n clears both valid bits and the scan state; no clear pass.
//  Stalls: out_stall holds only a final byte in the input register while a
//  verdict is still waiting, and in_stall holds off new bytes behind it.
// ---------------------------------------------------------------------------
module json_bracket_balance_checker_top
    import jbbc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    // input channel
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] text_byte,
    input  logic       final_byte,
    // result channel
    output logic       out_valid,
    input  logic       out_stall,
    output logic       is_valid,
    output logic [2:0] fail_reason
);

    beat_t    in_beat;
    beat_t    held_beat;
    logic     held_valid;
    logic     advance;
    logic     load;
    verdict_t verdict;

    assign in_beat.text_byte  = text_byte;
    assign in_beat.final_byte = final_byte;

    // A held beat moves on unless it is a final byte and the result
    // register still owns an untaken verdict.
    assign advance = held_valid & (~held_beat.final_byte | ~(out_valid & out_stall));
    assign load    = advance & held_beat.final_byte;

    jbbc_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_beat    (in_beat),
        .advance    (advance),
        .held_valid (held_valid),
        .held_beat  (held_beat)
    );

    jbbc_scan u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .beat    (held_beat),
        .verdict (verdict)
    );

    jbbc_out_stage u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (load),
        .verdict     (verdict),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .is_valid    (is_valid),
        .fail_reason (fail_reason)
    );

endmodule
